// ===== hw/rtl/mcct_pkg.sv =====
// Shared types and constants of the multi-channel compare timer.
package mcct_pkg;

  localparam int unsigned CHANNELS = 3;
  localparam int unsigned CNT_W    = 24;
  localparam int unsigned ADJ_W    = 4;
  localparam int unsigned DUR_W    = 32;

  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [ADJ_W-1:0] ADJ_RESET  = 4'd2;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_ALLOC = 3'd1,
    MODE_FREE  = 3'd2,
    MODE_START = 3'd3,
    MODE_STOP  = 3'd4,
    MODE_READ  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_RUNNING = 2'd3
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [1:0]         channel;
    logic               periodic;
    logic [DUR_W-1:0]   duration;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [1:0]          grant;
    logic [CNT_W-1:0]    remain;
    logic [CHANNELS-1:0] expired;
  } res_t;

endpackage

// ===== hw/rtl/mcct_engine.sv =====
// Timer state and the combinational command logic that updates it.
module mcct_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         exec_i,
  input  mcct_pkg::cmd_t               cmd_i,
  input  logic [mcct_pkg::ADJ_W-1:0]   reload_adjust_i,
  output mcct_pkg::res_t               res_o
);
  import mcct_pkg::*;

  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc, sel_cmp;
  logic [CNT_W-1:0]    cmp_q [CHANNELS];
  logic [CNT_W-1:0]    cmp_d [CHANNELS];
  logic [CNT_W-1:0]    per_q [CHANNELS];
  logic [CNT_W-1:0]    per_d [CHANNELS];
  logic [CHANNELS-1:0] alloc_q, alloc_d, run_q, run_d, rel_q, rel_d, sel;
  logic                ch_ok, sel_alloc, sel_run, found;

  assign cnt_inc = cnt_q + 1'b1;
  assign ch_ok   = cmd_i.channel < 2'(CHANNELS);

  always_comb begin
    sel     = '0;
    sel_cmp = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sel[i] = (cmd_i.channel == 2'(i));
      if (sel[i]) begin
        sel_cmp = cmp_q[i];
      end
    end
    sel_alloc = |(sel & alloc_q);
    sel_run   = |(sel & run_q);
  end

  always_comb begin
    cnt_d   = cnt_q;
    cmp_d   = cmp_q;
    per_d   = per_q;
    alloc_d = alloc_q;
    run_d   = run_q;
    rel_d   = rel_q;
    res_o   = '0;
    found   = 1'b0;
    res_o.status = ST_OK;
    case (cmd_i.mode)
      MODE_TICK: begin
        if (|run_q) begin
          cnt_d = cnt_inc;
          for (int i = 0; i < CHANNELS; i++) begin
            if (run_q[i] && (cmp_q[i] == cnt_inc)) begin
              res_o.expired[i] = 1'b1;
              if (rel_q[i]) begin
                cmp_d[i] = cnt_inc + per_q[i] - CNT_W'(reload_adjust_i);
              end else begin
                run_d[i] = 1'b0;
              end
            end
          end
        end
      end
      MODE_ALLOC: begin
        res_o.status = ST_NO_FREE;
        for (int i = 0; i < CHANNELS; i++) begin
          if (!found && !alloc_q[i]) begin
            found        = 1'b1;
            alloc_d[i]   = 1'b1;
            run_d[i]     = 1'b0;
            rel_d[i]     = cmd_i.periodic;
            res_o.grant  = 2'(i);
            res_o.status = ST_OK;
          end
        end
      end
      MODE_FREE: begin
        if (!ch_ok) begin
          res_o.status = ST_INVALID;
        end else begin
          alloc_d = alloc_q & ~sel;
          run_d   = run_q & ~sel;
        end
      end
      MODE_START: begin
        if (!ch_ok || !sel_alloc) begin
          res_o.status = ST_INVALID;
        end else if (sel_run) begin
          res_o.status = ST_RUNNING;
        end else if (cmd_i.duration >= DUR_W'(CNT_MAX)) begin
          res_o.status = ST_INVALID;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (sel[i]) begin
              cmp_d[i] = cnt_q + cmd_i.duration[CNT_W-1:0];
              per_d[i] = cmd_i.duration[CNT_W-1:0];
              run_d[i] = 1'b1;
            end
          end
        end
      end
      MODE_STOP: begin
        if (!ch_ok || !sel_run) begin
          res_o.status = ST_INVALID;
        end else begin
          run_d = run_q & ~sel;
        end
      end
      MODE_READ: begin
        if (!ch_ok) begin
          res_o.status = ST_INVALID;
        end else if (sel_run) begin
          if (sel_cmp > cnt_q) begin
            res_o.remain = sel_cmp - cnt_q;
          end else begin
            res_o.remain = (CNT_MAX - cnt_q) + sel_cmp;
          end
        end
      end
      default: begin
        res_o.status = ST_INVALID;
      end
    endcase
    // The shared counter stops and clears once no channel runs.
    if (!(|run_d)) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      alloc_q <= '0;
      run_q   <= '0;
      rel_q   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_q[i] <= '0;
        per_q[i] <= '0;
      end
    end else if (exec_i) begin
      cnt_q   <= cnt_d;
      alloc_q <= alloc_d;
      run_q   <= run_d;
      rel_q   <= rel_d;
      cmp_q   <= cmp_d;
      per_q   <= per_d;
    end
  end

endmodule

// ===== hw/rtl/multi_channel_compare_timer_unit.sv =====
// Three software timers on one 24-bit tick counter. Each beat on the input
// channel is one command (tick, allocate, free, start, stop or read) and
// yields exactly one result beat. A command is captured in an input register,
// executed against the timer state by combinational logic, and its result
// is held in an output register. The unit takes one beat per clock: the
// next command may enter while the previous result waits, and only a
// stalled output register holding a result together with a full input
// register stalls the input. A result becomes valid in the output register
// once its command has left the input register, which it does as soon as
// the output register is free. The reload adjustment register is written
// through cfg_we_i and should only change while no command is in flight.
module multi_channel_compare_timer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [mcct_pkg::ADJ_W-1:0]   cfg_wdata_i,
  // Command channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   mode_i,
  input  logic [1:0]                   channel_i,
  input  logic                         periodic_i,
  input  logic [mcct_pkg::DUR_W-1:0]   duration_us_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [1:0]                   allocated_channel_o,
  output logic [mcct_pkg::CNT_W-1:0]   remaining_us_o,
  output logic [2:0]                   expired_mask_o
);
  import mcct_pkg::*;

  logic [ADJ_W-1:0] adj_q;
  logic             in_vld_q, out_vld_q, advance, in_take;
  cmd_t             cmd_q;
  res_t             res, res_q;

  // The command in the input register executes when the output register
  // is empty or its result leaves in this same cycle.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= ADJ_RESET;
    end else if (cfg_we_i) begin
      adj_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q.mode     <= mode_e'(mode_i);
      cmd_q.channel  <= channel_i;
      cmd_q.periodic <= periodic_i;
      cmd_q.duration <= duration_us_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  mcct_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .exec_i          (advance),
    .cmd_i           (cmd_q),
    .reload_adjust_i (adj_q),
    .res_o           (res)
  );

  assign out_valid_o         = out_vld_q;
  assign status_o            = res_q.status;
  assign allocated_channel_o = res_q.grant;
  assign remaining_us_o      = res_q.remain;
  assign expired_mask_o      = res_q.expired;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the multi-channel compare timer unit.
`timescale 1ns / 1ps

module testbench;
  import mcct_pkg::*;

  // The mode field is three bits wide, so the two codes without a command
  // behind them must be driven as well.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [1:0] CH_NONE      = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LIMIT_CYCLES  = 250000;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [ADJ_W-1:0]     cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           mode_i        = '0;
  logic [1:0]           channel_i     = '0;
  logic                 periodic_i    = 1'b0;
  logic [DUR_W-1:0]     duration_us_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [1:0]           status_o;
  logic [1:0]           allocated_channel_o;
  logic [CNT_W-1:0]     remaining_us_o;
  logic [2:0]           expired_mask_o;

  multi_channel_compare_timer_unit u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .mode_i              (mode_i),
    .channel_i           (channel_i),
    .periodic_i          (periodic_i),
    .duration_us_i       (duration_us_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .allocated_channel_o (allocated_channel_o),
    .remaining_us_o      (remaining_us_o),
    .expired_mask_o      (expired_mask_o)
  );

  // Our own copy of the timer state. It is advanced once per accepted
  // command beat, in the order in which the unit accepts them.
  logic [CNT_W-1:0] tick_cnt;
  logic [CNT_W-1:0] compare_at [CHANNELS];
  logic [CNT_W-1:0] period_len [CHANNELS];
  bit               is_alloc   [CHANNELS];
  bit               is_running [CHANNELS];
  bit               is_periodic[CHANNELS];
  int unsigned      active_count;
  logic [ADJ_W-1:0] reload_adj = ADJ_RESET;

  res_t        outcome_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Knobs that the test tasks turn. Idle bursts are on by default; a
  // nonzero hold_off_len makes the result side stall in one long hold-off.
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_off_len = 0;

  initial begin
    tick_cnt     = '0;
    active_count = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      compare_at[i]  = '0;
      period_len[i]  = '0;
      is_alloc[i]    = 1'b0;
      is_running[i]  = 1'b0;
      is_periodic[i] = 1'b0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // A hard ceiling on the run; a hung handshake ends here.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[multi_channel_compare_timer_unit] ERROR");
    $finish;
  end

  // Stopping a channel: once nothing runs, the shared counter is cleared.
  function automatic void halt_timer(int c);
    is_running[c] = 1'b0;
    if (active_count > 0) active_count--;
    if (active_count == 0) tick_cnt = '0;
  endfunction

  // Executes one command against the local state and returns its result.
  function automatic res_t timer_command(input logic [2:0] op, input logic [1:0] ch,
                                         input logic per, input logic [DUR_W-1:0] dur);
    res_t r;
    bit   ch_ok;
    r        = '0;
    r.status = ST_OK;
    ch_ok    = (ch < CHANNELS);
    case (op)
      MODE_TICK: begin
        if (active_count != 0) begin
          tick_cnt = tick_cnt + 1'b1;
          for (int i = 0; i < CHANNELS; i++)
            if (is_running[i] && compare_at[i] == tick_cnt) r.expired[i] = 1'b1;
          for (int i = 0; i < CHANNELS; i++) begin
            if (r.expired[i]) begin
              if (is_periodic[i])
                compare_at[i] = tick_cnt + period_len[i] - CNT_W'(reload_adj);
              else
                halt_timer(i);
            end
          end
        end
      end
      MODE_ALLOC: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < CHANNELS; i++) begin
          if (!is_alloc[i] && r.status == ST_NO_FREE) begin
            is_alloc[i]    = 1'b1;
            is_running[i]  = 1'b0;
            is_periodic[i] = per;
            r.grant        = 2'(i);
            r.status       = ST_OK;
          end
        end
      end
      MODE_FREE: begin
        if (!ch_ok) begin
          r.status = ST_INVALID;
        end else begin
          if (is_running[ch]) halt_timer(ch);
          is_alloc[ch] = 1'b0;
        end
      end
      MODE_START: begin
        if (!ch_ok || !is_alloc[ch]) begin
          r.status = ST_INVALID;
        end else if (is_running[ch]) begin
          r.status = ST_RUNNING;
        end else if (dur >= DUR_W'(CNT_MAX)) begin
          r.status = ST_INVALID;
        end else begin
          compare_at[ch] = tick_cnt + dur[CNT_W-1:0];
          period_len[ch] = dur[CNT_W-1:0];
          is_running[ch] = 1'b1;
          active_count++;
        end
      end
      MODE_STOP: begin
        if (!ch_ok || !is_running[ch]) r.status = ST_INVALID;
        else halt_timer(ch);
      end
      MODE_READ: begin
        if (!ch_ok) begin
          r.status = ST_INVALID;
        end else if (is_running[ch]) begin
          // Past or equal compare values count the wrap through the top
          // of the counter, which is one short of a full turn.
          if (compare_at[ch] > tick_cnt) r.remain = compare_at[ch] - tick_cnt;
          else r.remain = (CNT_MAX - tick_cnt) + compare_at[ch];
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  // Offers one command beat and waits until the unit takes it. Inputs move
  // on the falling edge; the stall is looked at on the rising edge.
  task automatic send_cmd(input logic [2:0] op, input logic [1:0] ch,
                          input logic per, input logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= op;
    channel_i     <= ch;
    periodic_i    <= per;
    duration_us_i <= dur;
    do @(posedge clk_i); while (in_stall_o);
    outcome_q.push_back(timer_command(op, ch, per, dur));
  endtask

  // Drops valid and waits until every outstanding result has come back,
  // then gives the two-stage pipe time to drain.
  task automatic drain_unit();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes reload_adjust; callers drain the unit first.
  task automatic write_reload_adjust(input logic [ADJ_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    reload_adj = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stall bursts, or one long hold-off on request.
  always begin
    @(negedge clk_i);
    if (hold_off_len != 0) begin
      out_stall_i <= 1'b1;
      repeat (hold_off_len) @(negedge clk_i);
      hold_off_len = 0;
      out_stall_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Every result beat is matched against the oldest outstanding outcome.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d mask %0h",
                 $time, status_o, expired_mask_o);
        mismatch_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("allocated_channel", want.grant, allocated_channel_o);
        check_field("remaining_us", want.remain, remaining_us_o);
        check_field("expired_mask", want.expired, expired_mask_o);
      end
    end
  end

  // Error paths on an empty unit, allocation up to exhaustion, and starts
  // at the duration limits, including a zero duration.
  task automatic test_allocate_and_start();
    send_cmd(MODE_TICK, 2'd0, 1'b0, '0);
    send_cmd(MODE_READ, 2'd0, 1'b0, '0);
    send_cmd(MODE_READ, CH_NONE, 1'b0, '0);
    send_cmd(MODE_START, 2'd0, 1'b0, 32'd5);
    send_cmd(MODE_STOP, 2'd1, 1'b0, '0);
    send_cmd(MODE_FREE, 2'd2, 1'b0, '0);
    send_cmd(MODE_ALLOC, 2'd0, 1'b1, '0);
    send_cmd(MODE_ALLOC, 2'd0, 1'b0, '0);
    send_cmd(MODE_ALLOC, 2'd0, 1'b0, '0);
    send_cmd(MODE_ALLOC, 2'd0, 1'b1, '0);
    send_cmd(MODE_START, CH_NONE, 1'b0, 32'd5);
    send_cmd(MODE_START, 2'd1, 1'b0, 32'hFFFF_FFFF);
    send_cmd(MODE_START, 2'd1, 1'b0, 32'h00FF_FFFF);
    send_cmd(MODE_START, 2'd0, 1'b0, 32'd4);
    send_cmd(MODE_START, 2'd0, 1'b0, 32'd3);
    send_cmd(MODE_START, 2'd1, 1'b0, 32'd0);
    send_cmd(MODE_READ, 2'd1, 1'b0, '0);
    send_cmd(MODE_START, 2'd2, 1'b0, 32'h00FF_FFFE);
    send_cmd(MODE_READ, 2'd2, 1'b0, '0);
  endtask

  // The periodic channel fires and reloads with the reset adjustment, then
  // channels are stopped and freed until the counter clears.
  task automatic test_expiry_and_release();
    repeat (6) send_cmd(MODE_TICK, 2'd0, 1'b0, '0);
    send_cmd(MODE_READ, 2'd0, 1'b0, '0);
    send_cmd(MODE_STOP, 2'd2, 1'b0, '0);
    send_cmd(MODE_STOP, 2'd2, 1'b0, '0);
    send_cmd(MODE_FREE, 2'd0, 1'b0, '0);
    send_cmd(MODE_FREE, CH_NONE, 1'b0, '0);
    send_cmd(MODE_STOP, CH_NONE, 1'b0, '0);
    send_cmd(MODE_SPARE_A, 2'd1, 1'b1, 32'hFFFF_FFFF);
    send_cmd(MODE_SPARE_B, 2'd2, 1'b0, '0);
    send_cmd(MODE_FREE, 2'd1, 1'b0, '0);
    send_cmd(MODE_TICK, 2'd0, 1'b0, '0);
    send_cmd(MODE_FREE, 2'd2, 1'b0, '0);
    send_cmd(MODE_READ, 2'd1, 1'b0, '0);
    drain_unit();
  endtask

  // A periodic channel under the smallest, the largest and a middle
  // adjustment; the read shows where the reload landed.
  task automatic test_reload_adjust();
    logic [ADJ_W-1:0] settings[3];
    settings = '{4'd0, 4'd15, 4'd7};
    foreach (settings[k]) begin
      write_reload_adjust(settings[k]);
      for (int c = 0; c < CHANNELS; c++) send_cmd(MODE_FREE, 2'(c), 1'b0, '0);
      send_cmd(MODE_ALLOC, 2'd0, 1'b1, '0);
      send_cmd(MODE_START, 2'd0, 1'b0, 32'd17);
      repeat (20) send_cmd(MODE_TICK, 2'd0, 1'b0, '0);
      send_cmd(MODE_READ, 2'd0, 1'b0, '0);
      drain_unit();
    end
  endtask

  // The result side holds off for a long stretch while commands keep
  // coming, so the pipe fills and the unit stalls its input.
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int c = 0; c < CHANNELS; c++) send_cmd(MODE_FREE, 2'(c), 1'b0, '0);
    send_cmd(MODE_ALLOC, 2'd0, 1'b1, '0);
    send_cmd(MODE_START, 2'd0, 1'b0, 32'd10);
    drain_unit();
    hold_off_len = 80;
    repeat (10) send_cmd(MODE_TICK, 2'd0, 1'b0, '0);
    send_cmd(MODE_READ, 2'd0, 1'b0, '0);
    send_cmd(MODE_STOP, 2'd0, 1'b0, '0);
    drain_unit();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Weighted random commands. Ticks dominate and most durations are short,
  // so channels keep expiring; the rest covers every field bit and error.
  task automatic test_random_traffic(input int unsigned n_beats);
    int unsigned      pick;
    logic [2:0]       op;
    logic [1:0]       ch;
    logic [DUR_W-1:0] dur;
    repeat (n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = MODE_TICK;
      else if (pick < 55) op = MODE_ALLOC;
      else if (pick < 63) op = MODE_FREE;
      else if (pick < 80) op = MODE_START;
      else if (pick < 87) op = MODE_STOP;
      else if (pick < 97) op = MODE_READ;
      else op = ($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
      ch = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, CHANNELS - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) dur = $urandom_range(0, 40);
      else if (pick < 8) dur = $urandom_range(0, 65535);
      else if (pick == 8) dur = 32'h00FF_FFF0 + $urandom_range(0, 15);
      else dur = $urandom();
      send_cmd(op, ch, 1'($urandom_range(0, 1)), dur);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_allocate_and_start();
    test_expiry_and_release();
    test_reload_adjust();
    test_backpressure();

    // Random phases, each under its own adjustment; the last one runs with
    // no idle cycles on either side.
    write_reload_adjust(4'd0);
    test_random_traffic(67);
    drain_unit();
    write_reload_adjust(4'd15);
    test_random_traffic(67);
    drain_unit();
    write_reload_adjust(ADJ_W'($urandom_range(1, 14)));
    test_random_traffic(67);
    drain_unit();
    write_reload_adjust(ADJ_RESET);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(67);
    drain_unit();

    if (mismatch_count == 0) begin
      $display("[multi_channel_compare_timer_unit] OK");
    end else begin
      $display("[multi_channel_compare_timer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mcct_pkg.sv
hw/rtl/mcct_engine.sv
hw/rtl/multi_channel_compare_timer_unit.sv
sim/testbench.sv
